// File: hw/rtl/ccs_pkg.sv
// Shared types, codes and helpers for the conditional clause splitter.
package ccs_pkg;

  localparam int unsigned OFF_W  = 11;  // offset fields on the result word
  localparam int unsigned CLS_W  = 4;   // error clause field
  localparam int unsigned IDX_W  = 3;   // clause index field
  localparam int unsigned STAT_W = 4;   // status field

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [STAT_W-1:0] {
    ST_VALID        = 4'd0,
    ST_UNBAL        = 4'd1,
    ST_EMPTY_CLAUSE = 4'd2,
    ST_MULTI        = 4'd3,
    ST_MISSING      = 4'd4,
    ST_EMPTY_VALUE  = 4'd5,
    ST_EMPTY_COND   = 4'd6,
    ST_TOO_MANY     = 4'd7,
    ST_TOO_LONG     = 4'd8
  } status_e;

  typedef struct packed {
    logic             seen;
    logic [OFF_W-1:0] start_pos;
    logic [OFF_W-1:0] end_pos;
  } bounds_t;

  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [CLS_W-1:0] clause;
    logic [OFF_W-1:0] offset;
  } err_t;

  typedef struct packed {
    logic [OFF_W-1:0] value_start;
    logic [OFF_W-1:0] value_end;
    logic [OFF_W-1:0] cond_start;
    logic [OFF_W-1:0] cond_end;
  } rec_t;

  // Summary of a finished string handed to the emitter.
  typedef struct packed {
    logic             recs;        // emit stored clause records before status
    status_e          status;
    logic [CLS_W-1:0] err_clause;
    logic [OFF_W-1:0] err_offset;
  } fin_t;

  // C locale white space: space, TAB, LF, VT, FF, CR.
  function automatic logic is_white(logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  // First error of a class wins.
  function automatic err_t note(err_t e, status_e st, logic [CLS_W-1:0] cl,
                                logic [OFF_W-1:0] off);
    err_t r;
    r = e;
    if (!e.valid) begin
      r.valid  = 1'b1;
      r.status = st;
      r.clause = cl;
      r.offset = off;
    end
    return r;
  endfunction

  function automatic bounds_t widen(bounds_t b, logic [OFF_W-1:0] off);
    bounds_t r;
    r = b;
    if (!b.seen) begin
      r.seen      = 1'b1;
      r.start_pos = off;
    end
    r.end_pos = off + 1'b1;
    return r;
  endfunction

endpackage

// File: hw/rtl/ccs_in_if.sv
// Input channel: one byte of the conditional string per word, or none when has_char is low.
interface ccs_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       last;

  modport source (output valid, ch, has_char, last, input ready);
  modport sink   (input valid, ch, has_char, last, output ready);
endinterface

// File: hw/rtl/ccs_out_if.sv
// Result channel: clause records and the final status word.
interface ccs_out_if import ccs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             is_status;
  logic [IDX_W-1:0] clause_index;
  logic [OFF_W-1:0] value_start;
  logic [OFF_W-1:0] value_end;
  logic [OFF_W-1:0] cond_start;
  logic [OFF_W-1:0] cond_end;
  logic [STAT_W-1:0] status;
  logic [CLS_W-1:0] error_clause;
  logic [OFF_W-1:0] error_offset;
  logic             last_out;

  modport source (output valid, is_status, clause_index, value_start, value_end,
                  cond_start, cond_end, status, error_clause, error_offset,
                  last_out, input ready);
  modport sink   (input valid, is_status, clause_index, value_start, value_end,
                  cond_start, cond_end, status, error_clause, error_offset,
                  last_out, output ready);
endinterface

// File: hw/rtl/ccs_emit.sv
// Clause record store and result sequencer with the output register.
module ccs_emit import ccs_pkg::*; #(
  parameter int unsigned MAX_CLAUSES = 8,
  localparam int unsigned CNT_W  = $clog2(MAX_CLAUSES + 1),
  localparam int unsigned ADDR_W = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  rec_t              wr_rec,
  input  logic              fin_valid,
  input  fin_t              fin,
  input  logic [CNT_W-1:0]  fin_count,
  output logic              busy,
  ccs_out_if.source         out_chan
);

  rec_t mem [MAX_CLAUSES];

  logic             drain_active_r;
  logic [CNT_W-1:0] drain_idx_r;
  logic [CNT_W-1:0] drain_cnt_r;
  fin_t             drain_fin_r;

  logic             out_valid_r;
  logic             out_is_status_r;
  logic [IDX_W-1:0] out_idx_r;
  rec_t             out_rec_r;
  status_e          out_status_r;
  logic [CLS_W-1:0] out_eclause_r;
  logic [OFF_W-1:0] out_eoff_r;
  logic             out_last_r;

  logic step;
  logic emit_rec;

  assign step     = drain_active_r && (!out_valid_r || out_chan.ready);
  assign emit_rec = drain_idx_r != drain_cnt_r;
  assign busy     = drain_active_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_active_r <= 1'b0;
      drain_idx_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (fin_valid) begin
        drain_active_r <= 1'b1;
        drain_idx_r    <= '0;
      end else if (step) begin
        if (emit_rec) begin
          drain_idx_r <= drain_idx_r + 1'b1;
        end else begin
          drain_active_r <= 1'b0;
        end
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register doubles as the registered read port of the store.
  always_ff @(posedge clk) begin
    if (fin_valid) begin
      drain_cnt_r <= fin_count;
      drain_fin_r <= fin;
    end
    if (step) begin
      if (emit_rec) begin
        out_rec_r       <= mem[drain_idx_r[ADDR_W-1:0]];
        out_is_status_r <= 1'b0;
        out_idx_r       <= IDX_W'(drain_idx_r);
        out_status_r    <= ST_VALID;
        out_eclause_r   <= '0;
        out_eoff_r      <= '0;
        out_last_r      <= 1'b0;
      end else begin
        out_rec_r       <= '0;
        out_is_status_r <= 1'b1;
        out_idx_r       <= '0;
        out_status_r    <= drain_fin_r.status;
        out_eclause_r   <= drain_fin_r.err_clause;
        out_eoff_r      <= drain_fin_r.err_offset;
        out_last_r      <= 1'b1;
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.is_status    = out_is_status_r;
  assign out_chan.clause_index = out_idx_r;
  assign out_chan.value_start  = out_rec_r.value_start;
  assign out_chan.value_end    = out_rec_r.value_end;
  assign out_chan.cond_start   = out_rec_r.cond_start;
  assign out_chan.cond_end     = out_rec_r.cond_end;
  assign out_chan.status       = out_status_r;
  assign out_chan.error_clause = out_eclause_r;
  assign out_chan.error_offset = out_eoff_r;
  assign out_chan.last_out     = out_last_r;

endmodule

// File: hw/rtl/conditional_clause_splitter_core.sv
// Top level of the conditional clause splitter: byte parser and result emitter.
//
// Takes a "value @ condition; value @ condition" string one byte per word and
// splits it into clauses at top-level ';', finding the first top-level '@' of
// each clause and trimming C-locale white space from value and condition. The
// parser handles one byte per clock while no finished string drains: an
// accepted word lands in an input register and the parse logic updates the
// per-string state from it, so a steady stream runs at one byte per cycle. The
// word with last set closes the string; its results pass from the input
// register through the emitter's drain state into the output register. A
// clean string yields one record per clause (offsets of the trimmed value and
// condition, 11 bits, masked) and then a valid status word; any error yields
// only a status word, first-pass errors (unbalanced parentheses, empty clause,
// too many clauses, too long) taking priority over per-clause errors (multiple
// '@', missing '@', empty value, empty condition). Results leave through an
// output register, one per cycle while the sink is ready. While a finished
// string drains the parser holds the next string's first word in its input
// register, so that parser writes cannot overwrite records the emitter is
// still reading out. No clearing pass is needed after reset.
module conditional_clause_splitter_core import ccs_pkg::*; #(
  parameter int unsigned MAX_LEN     = 1024,
  parameter int unsigned MAX_CLAUSES = 8,
  localparam int unsigned POS_W  = $clog2(MAX_LEN + 1),
  localparam int unsigned CNT_W  = $clog2(MAX_CLAUSES + 1),
  localparam int unsigned ADDR_W = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1
) (
  input  logic      clk,
  input  logic      rst_n,
  ccs_in_if.sink    in_chan,
  ccs_out_if.source out_chan
);

  // Per-string parse state; all zero is the reset value.
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] depth;
    logic [OFF_W-1:0] clause_begin;
    logic [CNT_W-1:0] count;
    logic             nonspace;
    logic             sep_seen;
    logic [OFF_W-1:0] sep_pos;
    bounds_t          vb;
    bounds_t          cb;
    err_t             fpe;   // first-pass error
    err_t             ce;    // per-clause error
  } pstate_t;

  typedef struct packed {
    pstate_t           st;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    rec_t              rec;
  } close_t;

  // Ends the open clause at endpos; stores its record when it is non-empty and the store has room.
  function automatic close_t do_close(pstate_t s, logic [OFF_W-1:0] endpos);
    close_t r;
    r      = '0;
    r.st   = s;
    if (!s.nonspace) begin
      r.st.fpe = note(s.fpe, ST_EMPTY_CLAUSE, CLS_W'(s.count), s.clause_begin);
    end else if (s.count >= CNT_W'(MAX_CLAUSES)) begin
      r.st.fpe = note(s.fpe, ST_TOO_MANY, CLS_W'(MAX_CLAUSES), s.clause_begin);
    end else begin
      if (!s.sep_seen) begin
        r.st.ce = note(s.ce, ST_MISSING, CLS_W'(s.count), s.clause_begin);
      end else if (!s.vb.seen) begin
        r.st.ce = note(s.ce, ST_EMPTY_VALUE, CLS_W'(s.count), s.sep_pos);
      end else if (!s.cb.seen) begin
        r.st.ce = note(s.ce, ST_EMPTY_COND, CLS_W'(s.count), s.sep_pos + 1'b1);
      end
      r.wr              = 1'b1;
      r.addr            = s.count[ADDR_W-1:0];
      r.rec.value_start = s.vb.start_pos;
      r.rec.value_end   = s.vb.end_pos;
      r.rec.cond_start  = s.cb.start_pos;
      r.rec.cond_end    = s.cb.end_pos;
      r.st.count        = s.count + 1'b1;
    end
    r.st.clause_begin = endpos + 1'b1;
    r.st.nonspace     = 1'b0;
    r.st.sep_seen     = 1'b0;
    r.st.sep_pos      = '0;
    r.st.vb           = '0;
    r.st.cb           = '0;
    return r;
  endfunction

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_has_char_r;
  logic       s1_last_r;
  logic       s1_fire;
  logic       in_take;

  pstate_t state_r;
  pstate_t state_nxt;

  // Store write and end-of-string summary toward the emitter
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  rec_t              wr_rec;
  logic              fin_valid;
  fin_t              fin;
  logic [CNT_W-1:0]  fin_count;
  logic              emit_busy;

  assign s1_fire       = s1_valid_r && !emit_busy;
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch_r       <= in_chan.ch;
      s1_has_char_r <= in_chan.has_char;
      s1_last_r     <= in_chan.last;
    end
  end

  // Parse step: the byte first, then the end-of-string close on last.
  // At most one of the two closes stores a record: after a ';' the clause is
  // empty, so a close at end of string can only flag an empty clause.
  always_comb begin
    pstate_t          s;
    close_t           c1;
    close_t           c2;
    logic [OFF_W-1:0] off;
    logic             widen_en;

    s        = state_r;
    c1       = '0;
    c2       = '0;
    off      = OFF_W'(state_r.position);
    widen_en = 1'b0;

    if (s1_has_char_r && !s.fpe.valid) begin
      if (s.position >= POS_W'(MAX_LEN)) begin
        s.fpe = note(s.fpe, ST_TOO_LONG, CLS_W'(s.count), OFF_W'(MAX_LEN));
      end else begin
        s.position = s.position + 1'b1;
        if (s1_ch_r == CH_LPAREN) begin
          s.depth  = s.depth + 1'b1;
          widen_en = 1'b1;
        end else if (s1_ch_r == CH_RPAREN) begin
          if (s.depth == '0) begin
            // stray close paren
            s.fpe = note(s.fpe, ST_UNBAL, CLS_W'(s.count), off);
          end else begin
            s.depth  = s.depth - 1'b1;
            widen_en = 1'b1;
          end
        end else if (s1_ch_r == CH_SEMI && s.depth == '0) begin
          c1 = do_close(s, off);
          s  = c1.st;
        end else if (s1_ch_r == CH_AT && s.depth == '0) begin
          s.nonspace = 1'b1;
          if (s.sep_seen) begin
            s.ce = note(s.ce, ST_MULTI, CLS_W'(s.count), off);
          end else begin
            s.sep_seen = 1'b1;
            s.sep_pos  = off;
          end
        end else begin
          widen_en = !is_white(s1_ch_r);
        end
        if (widen_en) begin
          s.nonspace = 1'b1;
          if (s.sep_seen) begin
            s.cb = widen(s.cb, off);
          end else begin
            s.vb = widen(s.vb, off);
          end
        end
      end
    end

    if (s1_last_r && !s.fpe.valid) begin
      if (s.depth != '0) begin
        // open paren left at end of string
        s.fpe = note(s.fpe, ST_UNBAL, CLS_W'(s.count), OFF_W'(s.position));
      end else begin
        c2 = do_close(s, OFF_W'(s.position));
        s  = c2.st;
      end
    end

    wr_en   = s1_fire && (c1.wr || c2.wr);
    wr_addr = c1.wr ? c1.addr : c2.addr;
    wr_rec  = c1.wr ? c1.rec : c2.rec;

    fin_valid = s1_fire && s1_last_r;
    if (s.fpe.valid) begin
      fin.recs       = 1'b0;
      fin.status     = s.fpe.status;
      fin.err_clause = s.fpe.clause;
      fin.err_offset = s.fpe.offset;
      fin_count      = '0;
    end else if (s.ce.valid) begin
      fin.recs       = 1'b0;
      fin.status     = s.ce.status;
      fin.err_clause = s.ce.clause;
      fin.err_offset = s.ce.offset;
      fin_count      = '0;
    end else begin
      fin.recs       = 1'b1;
      fin.status     = ST_VALID;
      fin.err_clause = '0;
      fin.err_offset = '0;
      fin_count      = s.count;
    end

    // state returns to reset after each string
    state_nxt = s1_last_r ? pstate_t'('0) : s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  ccs_emit #(
    .MAX_CLAUSES (MAX_CLAUSES)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_rec    (wr_rec),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_count (fin_count),
    .busy      (emit_busy),
    .out_chan  (out_chan)
  );

  // Checks
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.position <= POS_W'(MAX_LEN))
    else $error("byte position ran past the length limit");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.count <= CNT_W'(MAX_CLAUSES))
    else $error("stored clause count ran past the store depth");

  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> state_r == pstate_t'('0))
    else $error("parse state not cleared after end of string");

  a_valid_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.is_status && out_chan.status == ST_VALID
    |-> out_chan.error_clause == '0 && out_chan.error_offset == '0)
    else $error("valid status word carries error fields");

endmodule

// File: tb/testbench.sv
// Self-checking bench for the conditional clause splitter: directed and random strings.
module testbench;
  import ccs_pkg::*;

  // Model sizes, kept in step with the core's defaults.
  localparam int unsigned LEN_MAX     = 1024;
  localparam int unsigned CLAUSE_MAX  = 8;
  // Run limits: watchdog, receiver hold-off, settle time after the last word.
  localparam int unsigned LIMIT       = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned RANDOM_WORDS_PER_PHASE = 20;
  localparam int unsigned PRINT_CAP   = 100;

  // One input word: a byte of the string plus its flags.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } byte_word_t;

  // One result word, laid out like the result channel.
  typedef struct packed {
    logic              is_status;
    logic [IDX_W-1:0]  clause_index;
    logic [OFF_W-1:0]  value_start;
    logic [OFF_W-1:0]  value_end;
    logic [OFF_W-1:0]  cond_start;
    logic [OFF_W-1:0]  cond_end;
    logic [STAT_W-1:0] status;
    logic [CLS_W-1:0]  error_clause;
    logic [OFF_W-1:0]  error_offset;
    logic              last_out;
  } split_word_t;

  typedef struct packed {
    logic             seen;
    logic [OFF_W-1:0] lo;
    logic [OFF_W-1:0] hi;
  } span_t;

  typedef struct packed {
    logic             hit;
    status_e          code;
    logic [CLS_W-1:0] clause;
    logic [OFF_W-1:0] offset;
  } fault_t;

  typedef struct packed {
    logic [OFF_W-1:0] vs;
    logic [OFF_W-1:0] ve;
    logic [OFF_W-1:0] cs;
    logic [OFF_W-1:0] ce;
  } clause_rec_t;

  // How one clause of a generated string gets broken.
  typedef enum int unsigned {
    FLAW_NONE, FLAW_NO_AT, FLAW_TWO_AT, FLAW_NO_VALUE, FLAW_NO_COND, FLAW_BLANK
  } flaw_e;

  // How a whole generated string gets broken.
  typedef enum int unsigned {
    MANGLE_CLAUSE, MANGLE_CLOSE, MANGLE_OPEN, MANGLE_CROWD, MANGLE_NOISE
  } mangle_e;

  logic clk;
  logic rst_n;

  ccs_in_if  in_if ();
  ccs_out_if out_if ();

  conditional_clause_splitter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if.sink),
    .out_chan (out_if.source)
  );

  // Words waiting for the sender, text under construction, expected results.
  byte_word_t  word_q[$];
  logic [7:0]  text_buf[$];
  split_word_t split_q[$];

  // Idle odds in percent, set per phase; receiver hold-off control.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_arm;
  bit          hold_used;
  int unsigned hold_left;

  int unsigned cycles;
  int unsigned mismatches;
  int unsigned strings_made;
  int unsigned words_taken;
  int unsigned records_checked;
  int unsigned statuses_checked;
  bit [8:0]    status_seen;

  // ---------------------------------------------------------------------------
  // Parser state of the predictor: one string at a time, cleared on the last
  // word and at reset.
  // ---------------------------------------------------------------------------
  logic [OFF_W-1:0] pos;          // bytes consumed so far
  logic [OFF_W-1:0] depth;        // open parentheses
  logic [OFF_W-1:0] clause_at;    // offset of the current clause's first byte
  logic [OFF_W-1:0] sep_at;       // offset of the clause's top-level '@'
  logic [CLS_W-1:0] n_clauses;    // non-empty clauses stored so far
  logic             has_text;     // current clause holds a non-space byte
  logic             has_sep;      // current clause has its '@'
  span_t            value_span;
  span_t            cond_span;
  fault_t           parse_fault;  // unbalanced, empty, too many, too long
  fault_t           clause_fault; // multiple @, missing @, empty value/cond
  clause_rec_t      kept[CLAUSE_MAX];

  // Queue tails.
  function automatic void put_byte(logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  function automatic void queue_word(byte_word_t w);
    word_q.insert(word_q.size(), w);
  endfunction

  function automatic void expect_word(split_word_t w);
    split_q.insert(split_q.size(), w);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    // past the cap the count still grows, the log stays readable
    if (mismatches <= PRINT_CAP)
      $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic void clear_parse();
    pos          = '0;
    depth        = '0;
    clause_at    = '0;
    sep_at       = '0;
    n_clauses    = '0;
    has_text     = 1'b0;
    has_sep      = 1'b0;
    value_span   = '0;
    cond_span    = '0;
    parse_fault  = '0;
    clause_fault = '0;
  endfunction

  // C locale white space: space and TAB through CR.
  function automatic logic blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Only the first fault of each class is kept.
  function automatic void log_fault(bit early, status_e code, logic [CLS_W-1:0] cl,
                                    logic [OFF_W-1:0] off);
    fault_t f;
    f = early ? parse_fault : clause_fault;
    if (!f.hit) begin
      f = '{hit: 1'b1, code: code, clause: cl, offset: off};
      if (early) parse_fault = f;
      else clause_fault = f;
    end
  endfunction

  function automatic span_t grow(span_t s, logic [OFF_W-1:0] off);
    if (!s.seen) begin
      s.seen = 1'b1;
      s.lo   = off;
    end
    s.hi = off + 1'b1;
    return s;
  endfunction

  function automatic void end_clause(logic [OFF_W-1:0] endpos);
    if (!has_text) begin
      log_fault(1'b1, ST_EMPTY_CLAUSE, n_clauses, clause_at);
    end else if (n_clauses >= CLAUSE_MAX) begin
      log_fault(1'b1, ST_TOO_MANY, CLS_W'(CLAUSE_MAX), clause_at);
    end else begin
      if (!has_sep)
        log_fault(1'b0, ST_MISSING, n_clauses, clause_at);
      else if (!value_span.seen)
        log_fault(1'b0, ST_EMPTY_VALUE, n_clauses, sep_at);
      else if (!cond_span.seen)
        log_fault(1'b0, ST_EMPTY_COND, n_clauses, sep_at + 1'b1);
      kept[n_clauses[IDX_W-1:0]] = '{value_span.lo, value_span.hi, cond_span.lo,
                                     cond_span.hi};
      n_clauses++;
    end
    clause_at  = endpos + 1'b1;
    has_text   = 1'b0;
    has_sep    = 1'b0;
    sep_at     = '0;
    value_span = '0;
    cond_span  = '0;
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    logic [OFF_W-1:0] off;
    // after a first-pass fault the rest of the string is dead
    if (parse_fault.hit) return;
    if (pos >= LEN_MAX) begin
      log_fault(1'b1, ST_TOO_LONG, n_clauses, OFF_W'(LEN_MAX));
      return;
    end
    off = pos;
    pos++;
    if (c == CH_LPAREN) begin
      depth++;
    end else if (c == CH_RPAREN) begin
      if (depth == 0) begin
        log_fault(1'b1, ST_UNBAL, n_clauses, off);
        return;
      end
      depth--;
    end else if (c == CH_SEMI && depth == 0) begin
      end_clause(off);
      return;
    end else if (c == CH_AT && depth == 0) begin
      has_text = 1'b1;
      if (has_sep) begin
        log_fault(1'b0, ST_MULTI, n_clauses, off);
      end else begin
        has_sep = 1'b1;
        sep_at  = off;
      end
      return;
    end
    // parentheses, nested ';' and '@' count as content of value or condition
    if (!blank(c)) begin
      has_text = 1'b1;
      if (has_sep) cond_span = grow(cond_span, off);
      else value_span = grow(value_span, off);
    end
  endfunction

  function automatic split_word_t status_word(status_e code, logic [CLS_W-1:0] cl,
                                              logic [OFF_W-1:0] off);
    split_word_t w;
    w              = '0;
    w.is_status    = 1'b1;
    w.status       = code;
    w.error_clause = cl;
    w.error_offset = off;
    w.last_out     = 1'b1;
    status_seen[code] = 1'b1;
    return w;
  endfunction

  // Last word of a string: close it and queue the words the core should send.
  function automatic void end_string();
    split_word_t w;
    if (!parse_fault.hit) begin
      if (depth != 0) log_fault(1'b1, ST_UNBAL, n_clauses, pos);
      else end_clause(pos);
    end
    if (parse_fault.hit) begin
      expect_word(status_word(parse_fault.code, parse_fault.clause,
                              parse_fault.offset));
    end else if (clause_fault.hit) begin
      expect_word(status_word(clause_fault.code, clause_fault.clause,
                              clause_fault.offset));
    end else begin
      for (int k = 0; k < n_clauses; k++) begin
        w              = '0;
        w.clause_index = IDX_W'(k);
        w.value_start  = kept[k].vs;
        w.value_end    = kept[k].ve;
        w.cond_start   = kept[k].cs;
        w.cond_end     = kept[k].ce;
        expect_word(w);
      end
      expect_word(status_word(ST_VALID, '0, '0));
    end
    clear_parse();
  endfunction

  // ---------------------------------------------------------------------------
  // String builders. Text collects in text_buf; send_text turns it into words,
  // sprinkling in words without a byte, and closes it with last.
  // ---------------------------------------------------------------------------
  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void add_ws(int unsigned most);
    repeat ($urandom_range(most))
      put_byte(($urandom_range(5) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(4)));
  endfunction

  function automatic logic [7:0] pick_letter();
    string set;
    set = "abxyz09_<=.";
    return set[$urandom_range(set.len() - 1)];
  endfunction

  // A short value or condition: letters, high bytes, and bracketed groups that
  // hide ';' and '@' from the splitter.
  function automatic void add_term();
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(7))
        0: begin
          put_byte(CH_LPAREN);
          put_byte(pick_letter());
          put_byte($urandom_range(1) ? CH_SEMI : CH_AT);
          put_byte(pick_letter());
          put_byte(CH_RPAREN);
        end
        1: put_byte(8'($urandom_range(128, 255)));
        default: put_byte(pick_letter());
      endcase
    end
  endfunction

  function automatic void add_clause(flaw_e flaw);
    if (flaw == FLAW_BLANK) begin
      add_ws(2);
      return;
    end
    add_ws(1);
    if (flaw != FLAW_NO_VALUE) add_term();
    add_ws(1);
    if (flaw != FLAW_NO_AT) put_byte(CH_AT);
    add_ws(1);
    if (flaw != FLAW_NO_COND) add_term();
    if (flaw == FLAW_TWO_AT) begin
      put_byte(CH_AT);
      add_term();
    end
    add_ws(1);
  endfunction

  function automatic void add_clauses(int unsigned n, int unsigned bad, flaw_e flaw);
    for (int unsigned k = 0; k < n; k++) begin
      if (k != 0) put_byte(CH_SEMI);
      add_clause((k == bad) ? flaw : FLAW_NONE);
    end
  endfunction

  // tail_gap: the string ends on a word that carries no byte.
  function automatic void send_text(bit tail_gap);
    int unsigned n;
    n = text_buf.size();
    strings_made++;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) queue_word('{8'($urandom), 1'b0, 1'b0});
      queue_word('{text_buf[i], 1'b1, (i == n - 1) && !tail_gap});
    end
    if (tail_gap || n == 0) queue_word('{8'($urandom), 1'b0, 1'b1});
    text_buf.delete();
  endfunction

  function automatic void add_random_string();
    int unsigned n;
    mangle_e     how;
    n = ($urandom_range(7) == 0) ? CLAUSE_MAX : $urandom_range(1, 3);
    // mostly well-formed strings, the rest broken in one way
    if ($urandom_range(99) < 70) begin
      add_clauses(n, 0, FLAW_NONE);
    end else begin
      how = mangle_e'($urandom_range(MANGLE_CLAUSE, MANGLE_NOISE));
      case (how)
        MANGLE_CLAUSE:
          add_clauses(n, $urandom_range(n - 1),
                      flaw_e'($urandom_range(FLAW_NO_AT, FLAW_BLANK)));
        MANGLE_CLOSE, MANGLE_OPEN: begin
          add_clauses(n, 0, FLAW_NONE);
          text_buf.insert($urandom_range(text_buf.size()),
                          (how == MANGLE_CLOSE) ? CH_RPAREN : CH_LPAREN);
        end
        MANGLE_CROWD: add_clauses($urandom_range(CLAUSE_MAX + 1, CLAUSE_MAX + 2), 0,
                                  FLAW_NONE);
        default: repeat ($urandom_range(1, 20)) put_byte(8'($urandom));
      endcase
    end
    send_text($urandom_range(7) == 0);
  endfunction

  // Directed strings: boundaries, the statuses and the priority between them.
  function automatic void add_directed();
    send_text(1'b0);                                   // no byte at all
    add_str("a@b");
    send_text(1'b0);
    add_str("\t x(;@) @\v y");                         // nested separators, trim
    put_byte(CH_CR);
    add_str("\f\n");
    send_text(1'b1);
    add_str(")a@b");                                   // stray close
    send_text(1'b0);
    add_str("a@(b");                                   // open at the end
    send_text(1'b0);
    add_str(";a@b");                                   // empty first clause
    send_text(1'b0);
    add_str("a@b; \t;c@d");                            // blank middle clause
    send_text(1'b0);
    add_str("a@b@c;;");                                // empty clause beats multiple @
    send_text(1'b0);
    add_str("ab;)");                                   // unbalanced beats missing @
    send_text(1'b0);
    add_str("ab");
    send_text(1'b0);
    add_str(" @b");
    send_text(1'b0);
    add_str("a@ ");
    send_text(1'b0);
    add_str("a@b@c");
    send_text(1'b0);
    for (int k = 0; k < CLAUSE_MAX; k++) begin         // full clause store
      if (k != 0) put_byte(CH_SEMI);
      put_byte(8'hFF);
      put_byte(CH_AT);
      put_byte(8'h00);
    end
    send_text(1'b0);
    for (int k = 0; k <= CLAUSE_MAX; k++) begin        // one clause too many
      if (k != 0) put_byte(CH_SEMI);
      add_str("a@b");
    end
    send_text(1'b0);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: offer the next queued word once the current one is taken.
  always @(posedge clk) begin : drive_words
    byte_word_t w;
    if (!rst_n) begin
      in_if.valid    <= 1'b0;
      in_if.ch       <= '0;
      in_if.has_char <= 1'b0;
      in_if.last     <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = word_q.pop_front();
        in_if.valid    <= 1'b1;
        in_if.ch       <= w.ch;
        in_if.has_char <= w.has_char;
        in_if.last     <= w.last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver hold-off: once armed, one long stretch of back-pressure so the
  // core fills up and stalls its input while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  // Check results against the oldest expectation first, then feed the
  // predictor with any word taken at the same edge.
  always @(posedge clk) begin : track_words
    split_word_t got;
    split_word_t want;
    string       diff;
    if (!rst_n) begin
      clear_parse();
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.is_status, out_if.clause_index, out_if.value_start,
                out_if.value_end, out_if.cond_start, out_if.cond_end, out_if.status,
                out_if.error_clause, out_if.error_offset, out_if.last_out};
        if (split_q.size() == 0) begin
          flag_mismatch($sformatf("result word %h with nothing pending", got));
        end else begin
          want = split_q.pop_front();
          diff = "";
          if (got.is_status != want.is_status)
            diff = {diff, $sformatf(" is_status %0d/%0d", got.is_status, want.is_status)};
          if (got.clause_index != want.clause_index)
            diff = {diff, $sformatf(" clause_index %0d/%0d", got.clause_index,
                                    want.clause_index)};
          if (got.value_start != want.value_start)
            diff = {diff, $sformatf(" value_start %0d/%0d", got.value_start,
                                    want.value_start)};
          if (got.value_end != want.value_end)
            diff = {diff, $sformatf(" value_end %0d/%0d", got.value_end, want.value_end)};
          if (got.cond_start != want.cond_start)
            diff = {diff, $sformatf(" cond_start %0d/%0d", got.cond_start,
                                    want.cond_start)};
          if (got.cond_end != want.cond_end)
            diff = {diff, $sformatf(" cond_end %0d/%0d", got.cond_end, want.cond_end)};
          if (got.status != want.status)
            diff = {diff, $sformatf(" status %0d/%0d", got.status, want.status)};
          if (got.error_clause != want.error_clause)
            diff = {diff, $sformatf(" error_clause %0d/%0d", got.error_clause,
                                    want.error_clause)};
          if (got.error_offset != want.error_offset)
            diff = {diff, $sformatf(" error_offset %0d/%0d", got.error_offset,
                                    want.error_offset)};
          if (got.last_out != want.last_out)
            diff = {diff, $sformatf(" last_out %0d/%0d", got.last_out, want.last_out)};
          if (diff != "") flag_mismatch({"got/want", diff});
          if (want.is_status) statuses_checked++;
          else records_checked++;
        end
      end
      if (in_if.valid && in_if.ready) begin
        words_taken++;
        if (in_if.has_char) scan_byte(in_if.ch);
        if (in_if.last) end_string();
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d result words still pending",
               cycles, split_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Three phases: sender mostly busy with a lazy receiver, then the reverse,
  // then both flat out with one long receiver hold-off. Each phase drains
  // completely before the next starts.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned target;
    rst_n            = 1'b0;
    strings_made     = 0;
    hold_arm         = 1'b0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      @(negedge clk);
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 85 : 0;
      recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 6 : 0;
      if (phase == 0) add_directed();
      target = word_q.size() + RANDOM_WORDS_PER_PHASE;
      while (word_q.size() < target) add_random_string();
      if (phase == 2) hold_arm = 1'b1;
      while (word_q.size() != 0 || in_if.valid || split_q.size() != 0) @(negedge clk);
    end
    // let any stray result word show up before the verdict
    repeat (SETTLE) @(negedge clk);
    $display("ran %0d strings as %0d input words; checked %0d clause records, %0d status words",
             strings_made, words_taken, records_checked, statuses_checked);
    $display("status codes produced (bit per code, 8 down to 0): %b", status_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: conditional_clause_splitter_core.f
hw/rtl/ccs_pkg.sv
hw/rtl/ccs_in_if.sv
hw/rtl/ccs_out_if.sv
hw/rtl/ccs_emit.sv
hw/rtl/conditional_clause_splitter_core.sv
tb/testbench.sv
